[src/permutation_table_engine_assert.svh]
// assertion macros shared by the permutation table engine
`ifndef PERMUTATION_TABLE_ENGINE_ASSERT_SVH
`define PERMUTATION_TABLE_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PTE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/pte_pkg.sv]
// types, constants and codes shared by the permutation table engine
`timescale 1ns / 1ps

package pte_pkg;

  // table geometry
  localparam int DEPTH      = 256;
  localparam int INDEX_BITS = $clog2(DEPTH);
  localparam int SIZE_BITS  = INDEX_BITS + 1;

  // request and random word widths
  localparam int REQ_BITS     = 3;
  localparam int RND_BITS     = 32;
  localparam int MOD_CNT_BITS = $clog2(RND_BITS + 1);

  // size after reset
  localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(DEPTH);

  // request codes
  typedef enum logic [REQ_BITS-1:0] {
    REQ_IDENTITY = 3'd0,
    REQ_LOOKUP   = 3'd1,
    REQ_EXCHANGE = 3'd2,
    REQ_SHUFFLE  = 3'd3,
    REQ_INVERT   = 3'd4
  } req_t;

  // sequencer states
  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_MOD  = 10'b00_0000_0010,
    ST_XRA  = 10'b00_0000_0100,
    ST_XRB  = 10'b00_0000_1000,
    ST_XWA  = 10'b00_0001_0000,
    ST_XWB  = 10'b00_0010_0000,
    ST_LK   = 10'b00_0100_0000,
    ST_INV1 = 10'b00_1000_0000,
    ST_INV2 = 10'b01_0000_0000,
    ST_RESP = 10'b10_0000_0000
  } state_t;

  // status of the remainder unit
  typedef struct packed {
    logic                  done;
    logic [INDEX_BITS-1:0] rem;
  } mod_status_t;

endpackage

[src/pte_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps

module pte_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     ren,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/pte_mod.sv]
// bit-serial remainder unit: random word modulo the active size
`timescale 1ns / 1ps

module pte_mod (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [pte_pkg::RND_BITS-1:0]      dividend,
  input  logic [pte_pkg::SIZE_BITS-1:0]     divisor,
  output pte_pkg::mod_status_t              status
);

  logic [pte_pkg::RND_BITS-1:0]     shreg;
  logic [pte_pkg::INDEX_BITS-1:0]   rem;
  logic [pte_pkg::MOD_CNT_BITS-1:0] cnt;
  logic                             busy;
  logic [pte_pkg::SIZE_BITS-1:0]    trial;
  logic [pte_pkg::SIZE_BITS-1:0]    diff;

  // one shift-compare-subtract step
  assign trial = {rem, shreg[pte_pkg::RND_BITS-1]};
  assign diff  = trial - divisor;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= pte_pkg::MOD_CNT_BITS'(pte_pkg::RND_BITS);
    end else if (busy) begin
      if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end else begin
        busy <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (busy && cnt != '0) begin
      shreg <= shreg << 1;
      if (trial >= divisor) begin
        rem <= diff[pte_pkg::INDEX_BITS-1:0];
      end else begin
        rem <= trial[pte_pkg::INDEX_BITS-1:0];
      end
    end
  end

  assign status.done = busy && (cnt == '0);
  assign status.rem  = rem;

endmodule

[src/permutation_table_engine.sv]
// top level of the permutation table engine: sequencer, tables and result register
//
// Requests arrive on the in_valid / in_ready channel, one beat per request
// (req_type, index_a, index_b, random_word). Every request gives one result
// beat (value, error) on out_valid / out_ready. The size register is written
// through cfg_wen / cfg_wdata; the user must write it only while the block is
// idle, which the block itself does not enforce. A write also restores the
// identity table. Sizes above the table depth act as the depth. Per request,
// identity, unknown codes and rejected indices go straight to the result state;
// lookup reads one entry; exchange reads both entries and writes both back;
// shuffle first waits on the bit-serial remainder unit, then exchanges; invert
// makes two passes over the tables (one entry per cycle, bounded by the single
// read port of each table). The result is offered in the same cycle as in_ready.
// in_ready is high only while the sequencer is idle. A result waits in the
// output register while the receiver stalls; the next request is accepted
// meanwhile, and its result is held back until the register frees.
// Reset restores size 256 and the identity table at once (per-entry valid
// bits); no clearing pass is needed. The scratch table is never cleared.
`timescale 1ns / 1ps
`include "permutation_table_engine_assert.svh"

module permutation_table_engine (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wen,
  input  logic [pte_pkg::SIZE_BITS-1:0]      cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [pte_pkg::REQ_BITS-1:0]       req_type,
  input  logic [pte_pkg::INDEX_BITS-1:0]     index_a,
  input  logic [pte_pkg::INDEX_BITS-1:0]     index_b,
  input  logic [pte_pkg::RND_BITS-1:0]       random_word,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pte_pkg::INDEX_BITS-1:0]     value,
  output logic                               error
);

  pte_pkg::state_t                  state;
  logic [pte_pkg::SIZE_BITS-1:0]    act_size;
  logic [pte_pkg::REQ_BITS-1:0]     op;
  logic [pte_pkg::INDEX_BITS-1:0]   a_idx;
  logic [pte_pkg::INDEX_BITS-1:0]   b_idx;
  logic [pte_pkg::INDEX_BITS-1:0]   va;
  logic [pte_pkg::INDEX_BITS-1:0]   x_idx;
  logic [pte_pkg::SIZE_BITS-1:0]    cnt;
  logic                             pend;
  logic [pte_pkg::INDEX_BITS-1:0]   res_value;
  logic                             res_error;
  logic [pte_pkg::DEPTH-1:0]        perm_vld;
  logic                             rd_vld;
  logic [pte_pkg::INDEX_BITS-1:0]   rd_addr;

  logic                             accept;
  logic                             a_bad;
  logic                             b_bad;
  logic                             cnt_live;
  logic                             resp_fire;
  logic                             id_clear;
  logic                             mod_start;
  pte_pkg::mod_status_t             mod_st;

  logic                             perm_wen;
  logic [pte_pkg::INDEX_BITS-1:0]   perm_waddr;
  logic [pte_pkg::INDEX_BITS-1:0]   perm_wdata;
  logic                             perm_ren;
  logic [pte_pkg::INDEX_BITS-1:0]   perm_raddr;
  logic [pte_pkg::INDEX_BITS-1:0]   perm_rdata;
  logic [pte_pkg::INDEX_BITS-1:0]   perm_word;
  logic                             scr_wen;
  logic                             scr_ren;
  logic [pte_pkg::INDEX_BITS-1:0]   scr_rdata;

  // handshake and range checks
  assign in_ready  = (state == pte_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign a_bad     = {1'b0, index_a} >= act_size;
  assign b_bad     = {1'b0, index_b} >= act_size;
  assign cnt_live  = cnt < act_size;
  assign resp_fire = (state == pte_pkg::ST_RESP) && (!out_valid || out_ready);
  assign id_clear  = accept && (req_type == pte_pkg::REQ_IDENTITY);
  assign mod_start = accept && (req_type == pte_pkg::REQ_SHUFFLE) && !a_bad;

  // entries never written since the last rebuild read as their own index
  assign perm_word = rd_vld ? perm_rdata : rd_addr;

  // permutation table ports
  always_comb begin
    perm_ren   = 1'b0;
    perm_raddr = cnt[pte_pkg::INDEX_BITS-1:0];
    perm_wen   = 1'b0;
    perm_waddr = x_idx;
    perm_wdata = scr_rdata;
    case (state)
      pte_pkg::ST_XRA: begin
        perm_ren   = 1'b1;
        perm_raddr = a_idx;
      end
      pte_pkg::ST_XRB: begin
        perm_ren   = 1'b1;
        perm_raddr = b_idx;
      end
      pte_pkg::ST_XWA: begin
        perm_wen   = 1'b1;
        perm_waddr = a_idx;
        perm_wdata = perm_word;
      end
      pte_pkg::ST_XWB: begin
        perm_wen   = 1'b1;
        perm_waddr = b_idx;
        perm_wdata = va;
      end
      pte_pkg::ST_INV1: begin
        perm_ren = cnt_live;
      end
      pte_pkg::ST_INV2: begin
        perm_wen = pend;
      end
      default: begin
      end
    endcase
  end

  // scratch table ports
  assign scr_wen = (state == pte_pkg::ST_INV1) && pend && ({1'b0, perm_word} < act_size);
  assign scr_ren = (state == pte_pkg::ST_INV2) && cnt_live;

  pte_ram #(
    .DEPTH (pte_pkg::DEPTH),
    .WIDTH (pte_pkg::INDEX_BITS)
  ) u_perm_ram (
    .clk   (clk),
    .wen   (perm_wen),
    .waddr (perm_waddr),
    .wdata (perm_wdata),
    .ren   (perm_ren),
    .raddr (perm_raddr),
    .rdata (perm_rdata)
  );

  pte_ram #(
    .DEPTH (pte_pkg::DEPTH),
    .WIDTH (pte_pkg::INDEX_BITS)
  ) u_scratch_ram (
    .clk   (clk),
    .wen   (scr_wen),
    .waddr (perm_word),
    .wdata (x_idx),
    .ren   (scr_ren),
    .raddr (cnt[pte_pkg::INDEX_BITS-1:0]),
    .rdata (scr_rdata)
  );

  pte_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (random_word),
    .divisor  (act_size),
    .status   (mod_st)
  );

  // per-entry valid bits of the permutation table
  always_ff @(posedge clk) begin
    if (rst || cfg_wen || id_clear) begin
      perm_vld <= '0;
    end else if (perm_wen) begin
      perm_vld[perm_waddr] <= 1'b1;
    end
  end

  // read-side tag travelling with the registered read data
  always_ff @(posedge clk) begin
    if (perm_ren) begin
      rd_vld  <= perm_vld[perm_raddr];
      rd_addr <= perm_raddr;
    end
  end

  // size register, clamped to the table depth
  always_ff @(posedge clk) begin
    if (rst) begin
      act_size <= pte_pkg::SIZE_RESET;
    end else if (cfg_wen) begin
      if (cfg_wdata > pte_pkg::SIZE_RESET) begin
        act_size <= pte_pkg::SIZE_RESET;
      end else begin
        act_size <= cfg_wdata;
      end
    end
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pte_pkg::ST_IDLE;
      cnt   <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        pte_pkg::ST_IDLE: begin
          if (accept) begin
            op        <= req_type;
            a_idx     <= index_a;
            b_idx     <= index_b;
            res_value <= '0;
            cnt       <= '0;
            pend      <= 1'b0;
            case (req_type)
              pte_pkg::REQ_LOOKUP: begin
                res_error <= a_bad;
                state     <= a_bad ? pte_pkg::ST_RESP : pte_pkg::ST_XRA;
              end
              pte_pkg::REQ_EXCHANGE: begin
                res_error <= a_bad || b_bad;
                state     <= (a_bad || b_bad) ? pte_pkg::ST_RESP : pte_pkg::ST_XRA;
              end
              pte_pkg::REQ_SHUFFLE: begin
                res_error <= a_bad;
                state     <= a_bad ? pte_pkg::ST_RESP : pte_pkg::ST_MOD;
              end
              pte_pkg::REQ_INVERT: begin
                res_error <= 1'b0;
                state     <= pte_pkg::ST_INV1;
              end
              default: begin
                res_error <= 1'b0;
                state     <= pte_pkg::ST_RESP;
              end
            endcase
          end
        end
        pte_pkg::ST_MOD: begin
          if (mod_st.done) begin
            b_idx <= mod_st.rem;
            state <= pte_pkg::ST_XRA;
          end
        end
        pte_pkg::ST_XRA: begin
          state <= (op == pte_pkg::REQ_LOOKUP) ? pte_pkg::ST_LK : pte_pkg::ST_XRB;
        end
        pte_pkg::ST_XRB: begin
          va    <= perm_word;
          state <= pte_pkg::ST_XWA;
        end
        pte_pkg::ST_XWA: begin
          state <= pte_pkg::ST_XWB;
        end
        pte_pkg::ST_XWB: begin
          state <= pte_pkg::ST_RESP;
        end
        pte_pkg::ST_LK: begin
          res_value <= perm_word;
          state     <= pte_pkg::ST_RESP;
        end
        pte_pkg::ST_INV1, pte_pkg::ST_INV2: begin
          pend  <= cnt_live;
          x_idx <= cnt[pte_pkg::INDEX_BITS-1:0];
          if (cnt_live) begin
            cnt <= cnt + 1'b1;
          end else if (!pend) begin
            cnt   <= '0;
            state <= (state == pte_pkg::ST_INV1) ? pte_pkg::ST_INV2 : pte_pkg::ST_RESP;
          end
        end
        pte_pkg::ST_RESP: begin
          if (resp_fire) begin
            state <= pte_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= pte_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (resp_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_fire) begin
      value <= res_value;
      error <= res_error;
    end
  end

  // checks
  `PTE_ASSERT_NEXT(a_busy_after_beat, accept, !in_ready, "sequencer ready right after a beat")
  `PTE_ASSERT_NOW(a_mod_done_in_wait, mod_st.done, state == pte_pkg::ST_MOD, "remainder outside wait")
  `PTE_ASSERT_NOW(a_error_no_value, out_valid && error, value == '0, "error beat carries a value")

endmodule

[dv/permutation_table_engine_test.sv]
// self-checking testbench for the permutation table engine
`timescale 1ns / 1ps

module permutation_table_engine_test;

  // request codes that the block ignores
  localparam logic [pte_pkg::REQ_BITS-1:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [pte_pkg::REQ_BITS-1:0] REQ_SPARE_LAST  = 3'd7;

  // cycles with no beat on any port before the run is abandoned
  localparam int unsigned STALL_LIMIT = 4000;
  // long receiver hold-off, to back the block up to its input
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS = 2000;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           cfg_wen = 1'b0;
  logic [pte_pkg::SIZE_BITS-1:0]  cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [pte_pkg::REQ_BITS-1:0]   req_type = '0;
  logic [pte_pkg::INDEX_BITS-1:0] index_a = '0;
  logic [pte_pkg::INDEX_BITS-1:0] index_b = '0;
  logic [pte_pkg::RND_BITS-1:0]   random_word = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [pte_pkg::INDEX_BITS-1:0] value;
  logic                           error;

  typedef struct packed {
    logic [pte_pkg::INDEX_BITS-1:0] value;
    logic                           error;
  } perm_result_t;

  // mirror of the permutation table and the results it implies
  class perm_scoreboard;
    logic [pte_pkg::INDEX_BITS-1:0] perm_map [pte_pkg::DEPTH];
    logic [pte_pkg::SIZE_BITS-1:0]  size_reg;
    perm_result_t                   awaited[$];
    int unsigned                    failures;

    function new();
      size_reg = pte_pkg::SIZE_RESET;
      failures = 0;
      make_identity();
    endfunction

    function void make_identity();
      for (int i = 0; i < pte_pkg::DEPTH; i++) perm_map[i] = pte_pkg::INDEX_BITS'(i);
    endfunction

    // entries in play: sizes above the depth act as the depth
    function int unsigned span();
      return (size_reg > pte_pkg::DEPTH) ? pte_pkg::DEPTH : size_reg;
    endfunction

    function void set_size(logic [pte_pkg::SIZE_BITS-1:0] sz);
      size_reg = sz;
      make_identity();
    endfunction

    function bit drained();
      return awaited.size() == 0;
    endfunction

    function void swap(int unsigned x, int unsigned y);
      logic [pte_pkg::INDEX_BITS-1:0] t;
      t = perm_map[x];
      perm_map[x] = perm_map[y];
      perm_map[y] = t;
    endfunction

    // apply one accepted request and queue the result it must give
    function void note_request(logic [pte_pkg::REQ_BITS-1:0] rt,
                               logic [pte_pkg::INDEX_BITS-1:0] a,
                               logic [pte_pkg::INDEX_BITS-1:0] b,
                               logic [pte_pkg::RND_BITS-1:0] rnd);
      int unsigned n;
      perm_result_t res;
      logic [pte_pkg::INDEX_BITS-1:0] scratch [pte_pkg::DEPTH];
      n = span();
      res = '0;
      case (rt)
        pte_pkg::REQ_IDENTITY: make_identity();
        pte_pkg::REQ_LOOKUP: begin
          if (a >= n) res.error = 1'b1;
          else res.value = perm_map[a];
        end
        pte_pkg::REQ_EXCHANGE: begin
          if (a >= n || b >= n) res.error = 1'b1;
          else swap(a, b);
        end
        pte_pkg::REQ_SHUFFLE: begin
          if (a >= n) res.error = 1'b1;
          else swap(a, rnd % n);
        end
        pte_pkg::REQ_INVERT: begin
          for (int x = 0; x < n; x++)
            if (perm_map[x] < n) scratch[perm_map[x]] = pte_pkg::INDEX_BITS'(x);
          for (int x = 0; x < n; x++) perm_map[x] = scratch[x];
        end
        default: ;
      endcase
      awaited.push_back(res);
    endfunction

    // compare one result beat with the oldest expectation
    function void check_result(logic [pte_pkg::INDEX_BITS-1:0] v, logic e);
      perm_result_t exp_res;
      if (awaited.size() == 0) begin
        $error("result beat with nothing expected: value %0d error %0d", v, e);
        failures++;
        return;
      end
      exp_res = awaited.pop_front();
      if (v !== exp_res.value) begin
        $error("value: expected %0d, actual %0d", exp_res.value, v);
        failures++;
      end
      if (e !== exp_res.error) begin
        $error("error: expected %0d, actual %0d", exp_res.error, e);
        failures++;
      end
    endfunction
  endclass

  perm_scoreboard board = new();
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int unsigned stall_count = 0;

  permutation_table_engine dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .index_a     (index_a),
    .index_b     (index_b),
    .random_word (random_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value       (value),
    .error       (error)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wen) begin
      stall_count <= 0;
    end else if (stall_count + 1 >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // offer one request beat and wait for it to be taken
  task automatic send_req(logic [pte_pkg::REQ_BITS-1:0] rt,
                          logic [pte_pkg::INDEX_BITS-1:0] a,
                          logic [pte_pkg::INDEX_BITS-1:0] b,
                          logic [pte_pkg::RND_BITS-1:0] rnd);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= rt;
    index_a     <= a;
    index_b     <= b;
    random_word <= rnd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(rt, a, b, rnd);
  endtask

  // change the size once every result is home and the block is idle
  task automatic write_size(logic [pte_pkg::SIZE_BITS-1:0] sz);
    in_valid <= 1'b0;
    @(posedge clk);
    while (!(board.drained() && in_ready)) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= sz;
    @(posedge clk);
    cfg_wen <= 1'b0;
    board.set_size(sz);
  endtask

  function automatic logic [pte_pkg::INDEX_BITS-1:0] index_within(int unsigned n);
    if (n == 0) return pte_pkg::INDEX_BITS'($urandom());
    return pte_pkg::INDEX_BITS'($urandom_range(0, n - 1));
  endfunction

  function automatic logic [pte_pkg::INDEX_BITS-1:0] index_beyond(int unsigned n);
    if (n >= pte_pkg::DEPTH) return pte_pkg::INDEX_BITS'($urandom());
    return pte_pkg::INDEX_BITS'($urandom_range(n, pte_pkg::DEPTH - 1));
  endfunction

  // mostly well-formed requests, some spare codes and bad indices
  task automatic send_random(ref int unsigned counted);
    int unsigned n, pick;
    logic [pte_pkg::REQ_BITS-1:0] rt;
    logic [pte_pkg::INDEX_BITS-1:0] a, b;
    n    = board.span();
    pick = $urandom_range(0, 99);
    a    = index_within(n);
    b    = index_within(n);
    if (pick < 30) rt = pte_pkg::REQ_LOOKUP;
    else if (pick < 55) rt = pte_pkg::REQ_EXCHANGE;
    else if (pick < 75) rt = pte_pkg::REQ_SHUFFLE;
    else if (pick < 81) rt = pte_pkg::REQ_IDENTITY;
    else if (pick < 86) rt = pte_pkg::REQ_INVERT;
    else if (pick < 90)
      rt = pte_pkg::REQ_BITS'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
    else begin
      rt = (pick < 94) ? pte_pkg::REQ_LOOKUP :
           (pick < 97) ? pte_pkg::REQ_EXCHANGE : pte_pkg::REQ_SHUFFLE;
      if ($urandom_range(0, 1)) a = index_beyond(n);
      else b = index_beyond(n);
    end
    send_req(rt, a, b, $urandom());
    if (rt <= pte_pkg::REQ_INVERT) counted++;
  endtask

  // mostly small sizes, now and then the full table, zero or beyond the depth
  function automatic logic [pte_pkg::SIZE_BITS-1:0] pick_size();
    int unsigned p;
    p = $urandom_range(0, 19);
    if (p == 0) return '0;
    if (p == 1)
      return pte_pkg::SIZE_BITS'($urandom_range(pte_pkg::DEPTH + 1,
                                                (1 << pte_pkg::SIZE_BITS) - 1));
    if (p < 4) return pte_pkg::SIZE_BITS'(pte_pkg::DEPTH);
    return pte_pkg::SIZE_BITS'($urandom_range(1, 24));
  endfunction

  // result sink with random stalls and a couple of long hold-offs
  initial begin : result_sink
    int unsigned gap;
    int unsigned seen;
    seen = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (seen % 50 == 0) rx_steady = ($urandom_range(0, 3) == 0);
      gap = rx_steady ? 0 : $urandom_range(0, 19);
      if (seen == 400 || seen == 1300) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_result(value, error);
      seen++;
    end
  end

  // reset, directed requests, random phases, drain
  initial begin : request_source
    int unsigned counted;
    counted = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // full table after reset: extremes, swaps, self-exchange, invert
    send_req(pte_pkg::REQ_LOOKUP, '0, '0, '0);
    send_req(pte_pkg::REQ_LOOKUP, '1, '1, '1);
    send_req(pte_pkg::REQ_EXCHANGE, '0, '1, '0);
    send_req(pte_pkg::REQ_LOOKUP, '0, '0, '0);
    send_req(pte_pkg::REQ_EXCHANGE, 8'd7, 8'd7, '0);
    send_req(pte_pkg::REQ_SHUFFLE, '1, '0, '1);
    send_req(pte_pkg::REQ_SHUFFLE, 8'd3, '0, '0);
    send_req(pte_pkg::REQ_INVERT, '0, '0, '0);
    send_req(pte_pkg::REQ_LOOKUP, '1, '0, '0);
    send_req(pte_pkg::REQ_IDENTITY, '1, '1, '1);
    for (int c = REQ_SPARE_FIRST; c <= REQ_SPARE_LAST; c++)
      send_req(pte_pkg::REQ_BITS'(c), '1, '1, '1);

    // single element
    write_size(pte_pkg::SIZE_BITS'(1));
    send_req(pte_pkg::REQ_LOOKUP, '0, '0, '0);
    send_req(pte_pkg::REQ_LOOKUP, 8'd1, '0, '0);
    send_req(pte_pkg::REQ_EXCHANGE, '0, 8'd1, '0);
    send_req(pte_pkg::REQ_SHUFFLE, '0, '0, $urandom());
    send_req(pte_pkg::REQ_INVERT, '0, '0, '0);

    // empty permutation: every index is out of range
    write_size('0);
    send_req(pte_pkg::REQ_LOOKUP, '0, '0, '0);
    send_req(pte_pkg::REQ_EXCHANGE, '0, '0, '0);
    send_req(pte_pkg::REQ_SHUFFLE, '0, '0, $urandom());
    send_req(pte_pkg::REQ_IDENTITY, '0, '0, '0);
    send_req(pte_pkg::REQ_INVERT, '0, '0, '0);

    // size beyond the depth behaves as the depth
    write_size('1);
    send_req(pte_pkg::REQ_EXCHANGE, '1, '0, '0);
    send_req(pte_pkg::REQ_INVERT, '0, '0, '0);
    send_req(pte_pkg::REQ_LOOKUP, '1, '0, '0);

    // random phases, each under its own size
    while (counted < RANDOM_ITEMS) begin
      write_size(pick_size());
      tx_steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(30, 120)) send_random(counted);
    end
    tx_steady = 1'b0;

    // drain and give stray beats a chance to show
    in_valid <= 1'b0;
    @(posedge clk);
    while (!board.drained()) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.failures == 0 && board.drained()) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
